// ----- src/mpdl_pkg.sv -----
// Shared types and constants for the multichannel pool delay line.
// Used by every module of the block but mpdl_ram; depends on nothing else.
package mpdl_pkg;

    localparam int POOL_WORDS  = 4096;
    localparam int CHANNELS    = 4;
    localparam int NUM_REGS    = 4;
    localparam int DELAY_W     = 13;
    localparam int POS_W       = 12;
    localparam int SAMPLE_W    = 32;
    localparam int CH_W        = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int ADDR_W      = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
    localparam int SUM_W       = (DELAY_W + 2 > ADDR_W) ? DELAY_W + 2 : ADDR_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_CLEAR  = 1'b1;

    // How the back end produces the result of one sample.
    typedef enum logic [1:0] {
        MODE_BYPASS,
        MODE_ZERO,
        MODE_MEM
    } mode_t;

    typedef struct packed {
        mode_t               mode;
        logic [CH_W-1:0]     ch;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] sample;
    } op_t;

endpackage

// ----- src/mpdl_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Read-first on a same-address collision. No dependencies.
module mpdl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/mpdl_front.sv -----
// Front end: delay registers, region layout, write positions and lap flags.
// Classifies each accepted item and queues sample operations. Uses mpdl_pkg.
module mpdl_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [mpdl_pkg::CH_W-1:0]     s_channel,
    input  logic [mpdl_pkg::SAMPLE_W-1:0] s_sample_in,
    input  logic                          cfg_we,
    input  logic [mpdl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mpdl_pkg::DELAY_W-1:0]  cfg_wdata,
    output logic                          push,
    output mpdl_pkg::op_t                 push_op,
    input  logic                          queue_full
);
    import mpdl_pkg::*;

    localparam logic [CH_W:0]      CH_LIMIT  = (CH_W + 1)'(CHANNELS);
    localparam logic [CFG_IDX_W:0] IDX_LIMIT = (CFG_IDX_W + 1)'(CHANNELS);
    localparam logic [SUM_W-1:0]   POOL_LIM  = SUM_W'(POOL_WORDS);

    logic [DELAY_W-1:0]  delay_reg  [NUM_REGS];
    logic [DELAY_W-1:0]  delay_next [NUM_REGS];
    logic [POS_W-1:0]    pos_reg    [NUM_REGS];
    logic [POS_W-1:0]    pos_next   [NUM_REGS];
    logic [NUM_REGS-1:0] lapped_reg;
    logic [NUM_REGS-1:0] lapped_next;

    logic [SUM_W-1:0]   base [NUM_REGS];
    logic [SUM_W-1:0]   cfg_total;
    logic [SUM_W-1:0]   addr_sum;
    logic [DELAY_W-1:0] sel_len;
    logic [POS_W-1:0]   sel_pos;
    logic [DELAY_W-1:0] pos_inc;
    logic [POS_W-1:0]   pos_adv;
    logic               wrap;
    logic               ch_present;
    logic               delayed;
    logic               accept;
    logic               cfg_ok;
    logic               wipe;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && (s_action == ACTION_SAMPLE);

    // Each region starts where the regions of the lower channels end.
    always_comb begin
        base[0] = '0;
        for (int k = 1; k < NUM_REGS; k++) begin
            base[k] = base[k-1] + SUM_W'(delay_reg[k-1]);
        end
    end

    assign ch_present = {1'b0, s_channel} < CH_LIMIT;
    assign sel_len    = delay_reg[s_channel];
    assign sel_pos    = pos_reg[s_channel];
    assign delayed    = ch_present && (sel_len != '0);
    assign pos_inc    = DELAY_W'(sel_pos) + DELAY_W'(1);
    assign wrap       = (pos_inc == sel_len);
    assign pos_adv    = wrap ? '0 : pos_inc[POS_W-1:0];
    assign addr_sum   = base[s_channel] + SUM_W'(sel_pos);

    // A word is only valid to read once the channel has gone once around its
    // ring since the last wipe; before that the word reads as zero.
    always_comb begin
        push_op.ch     = s_channel;
        push_op.addr   = addr_sum[ADDR_W-1:0];
        push_op.sample = s_sample_in;
        if (!delayed) begin
            push_op.mode = MODE_BYPASS;
        end else if (lapped_reg[s_channel]) begin
            push_op.mode = MODE_MEM;
        end else begin
            push_op.mode = MODE_ZERO;
        end
    end

    always_comb begin
        cfg_total = '0;
        for (int k = 0; k < NUM_REGS; k++) begin
            if (k < CHANNELS) begin
                cfg_total = cfg_total + SUM_W'((CFG_IDX_W'(k) == cfg_index) ?
                                                cfg_wdata : delay_reg[k]);
            end
        end
    end

    assign cfg_ok = cfg_we && ({1'b0, cfg_index} < IDX_LIMIT) &&
                    (cfg_total <= POOL_LIM) && (cfg_wdata != delay_reg[cfg_index]);
    assign wipe   = cfg_ok || (accept && (s_action == ACTION_CLEAR));

    always_comb begin
        delay_next  = delay_reg;
        pos_next    = pos_reg;
        lapped_next = lapped_reg;
        if (cfg_ok) begin
            delay_next[cfg_index] = cfg_wdata;
        end
        if (wipe) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                pos_next[k] = '0;
            end
            lapped_next = '0;
        end else if (push && delayed) begin
            pos_next[s_channel] = pos_adv;
            if (wrap) begin
                lapped_next[s_channel] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                delay_reg[k] <= '0;
                pos_reg[k]   <= '0;
            end
            lapped_reg <= '0;
        end else begin
            delay_reg  <= delay_next;
            pos_reg    <= pos_next;
            lapped_reg <= lapped_next;
        end
    end

endmodule

// ----- src/mpdl_queue.sv -----
// Short first-in first-out queue of sample operations between front and back.
// Uses mpdl_pkg for the entry type and depth.
module mpdl_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mpdl_pkg::op_t push_op,
    output logic          full,
    input  logic          pop,
    output mpdl_pkg::op_t pop_op,
    output logic          pop_valid
);
    import mpdl_pkg::*;

    localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_op    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/mpdl_back.sv -----
// Back end: issues the pool read and write that the mode of each queued operation calls for and
// holds the result in an output register. Uses mpdl_pkg.
module mpdl_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pop_valid,
    input  mpdl_pkg::op_t                 pop_op,
    output logic                          pop,
    output logic                          ram_we,
    output logic                          ram_re,
    output logic [mpdl_pkg::ADDR_W-1:0]   ram_addr,
    output logic [mpdl_pkg::SAMPLE_W-1:0] ram_wdata,
    input  logic [mpdl_pkg::SAMPLE_W-1:0] ram_rdata,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mpdl_pkg::CH_W-1:0]     m_channel_out,
    output logic [mpdl_pkg::SAMPLE_W-1:0] m_sample_out
);
    import mpdl_pkg::*;

    logic                stage_valid_reg;
    logic                stage_valid_next;
    mode_t               stage_mode_reg;
    logic [CH_W-1:0]     stage_ch_reg;
    logic [SAMPLE_W-1:0] stage_sample_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CH_W-1:0]     out_ch_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic [SAMPLE_W-1:0] result;
    logic                out_load;
    logic                stage_free;

    // The read stage only advances into a free output register, so the RAM
    // read data holds still while the stage waits.
    assign out_load   = stage_valid_reg && (!out_valid_reg || m_ready);
    assign stage_free = !stage_valid_reg || out_load;
    assign pop        = pop_valid && stage_free;

    assign ram_re    = pop && (pop_op.mode == MODE_MEM);
    assign ram_we    = pop && (pop_op.mode != MODE_BYPASS);
    assign ram_addr  = pop_op.addr;
    assign ram_wdata = pop_op.sample;

    always_comb begin
        unique case (stage_mode_reg)
            MODE_MEM:    result = ram_rdata;
            MODE_ZERO:   result = '0;
            MODE_BYPASS: result = stage_sample_reg;
            default:     result = stage_sample_reg;
        endcase
    end

    always_comb begin
        if (pop) begin
            stage_valid_next = 1'b1;
        end else if (out_load) begin
            stage_valid_next = 1'b0;
        end else begin
            stage_valid_next = stage_valid_reg;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            stage_mode_reg   <= pop_op.mode;
            stage_ch_reg     <= pop_op.ch;
            stage_sample_reg <= pop_op.sample;
        end
        if (out_load) begin
            out_ch_reg     <= stage_ch_reg;
            out_sample_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_channel_out = out_ch_reg;
    assign m_sample_out  = out_sample_reg;

endmodule

// ----- src/multichannel_pool_delay_line_unit.sv -----
// Top level of the multichannel pool delay line.
// Depends on mpdl_pkg, mpdl_front, mpdl_queue, mpdl_back and mpdl_ram.
//
// Up to four channels share one pool of 32-bit words; each channel with a
// nonzero delay owns a ring region laid out in channel order. The input
// channel (s_valid/s_ready) carries an action, a channel and a sample word.
// A sample transfer returns one result on the output channel (m_valid/m_ready):
// the word stored delay samples earlier on that channel, zero if the ring has
// not yet filled, or the input itself when the delay is zero. A clear transfer
// resets the write positions and lap flags, so the rings read as zero, and returns nothing.
// Delay registers are written through cfg_we/cfg_index/cfg_wdata; a write that
// overfills the pool is ignored, and a write that changes a value wipes.
// Throughput is one item per cycle while the receiver keeps m_ready high, set by
// the single pool RAM port pair (one read and one write per cycle). A result
// passes from the queue into the RAM read stage and then into the output
// register. When the receiver stalls, the output register, the read stage and
// a two-entry queue fill up before s_ready drops.
// Reset clears delays, positions and all handshake state; no clearing pass is
// needed because per-channel lap flags mark which rings have been filled.
module multichannel_pool_delay_line_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_action,
    input  logic [mpdl_pkg::CH_W-1:0]      s_channel,
    input  logic [mpdl_pkg::SAMPLE_W-1:0]  s_sample_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mpdl_pkg::CH_W-1:0]      m_channel_out,
    output logic [mpdl_pkg::SAMPLE_W-1:0]  m_sample_out,
    input  logic                           cfg_we,
    input  logic [mpdl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mpdl_pkg::DELAY_W-1:0]   cfg_wdata
);
    import mpdl_pkg::*;

    logic                push;
    op_t                 push_op;
    logic                queue_full;
    logic                pop;
    op_t                 pop_op;
    logic                pop_valid;
    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_addr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic [SAMPLE_W-1:0] ram_rdata;

    mpdl_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_channel   (s_channel),
        .s_sample_in (s_sample_in),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .push        (push),
        .push_op     (push_op),
        .queue_full  (queue_full)
    );

    mpdl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_op   (push_op),
        .full      (queue_full),
        .pop       (pop),
        .pop_op    (pop_op),
        .pop_valid (pop_valid)
    );

    mpdl_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_op        (pop_op),
        .pop           (pop),
        .ram_we        (ram_we),
        .ram_re        (ram_re),
        .ram_addr      (ram_addr),
        .ram_wdata     (ram_wdata),
        .ram_rdata     (ram_rdata),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_channel_out (m_channel_out),
        .m_sample_out  (m_sample_out)
    );

    mpdl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (POOL_WORDS)
    ) u_pool (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // A clear transfer never reaches the queue or the pool.
    a_clear_not_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_action == ACTION_CLEAR)) |-> !push)
        else $error("clear transfer was queued");

    // Every pool read is paired with the write of the new sample.
    a_read_with_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |-> (ram_we && pop))
        else $error("pool read without matching write");

    // A result that appears in an empty output register comes from a popped operation that passed the read stage.
    a_result_from_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(pop, 2))
        else $error("result appeared without a queued operation");

endmodule
